[hdl/wrhp_pkg.sv]
package wrhp_pkg;

  // Four-character tags, first character in the most significant byte.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Header bounds.
  localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
  localparam logic [31:0] RIFF_TAG_END   = 32'd3;
  localparam logic [31:0] WAVE_TAG_END   = 32'd11;
  localparam logic [31:0] MIN_FMT_BYTES  = 32'd16;
  localparam logic [15:0] FORMAT_PCM     = 16'd1;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HEADER  = 3'd1;
  localparam logic [2:0] ST_SIZE    = 3'd2;
  localparam logic [2:0] ST_NOT_PCM = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_EXPECTED_RATE     = 2'd0;
  localparam logic [1:0] REG_EXPECTED_CHANNELS = 2'd1;
  localparam logic [1:0] REG_EXPECTED_BITS     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] RESET_RATE     = 32'd16000;
  localparam logic [15:0] RESET_CHANNELS = 16'd1;
  localparam logic [15:0] RESET_BITS     = 16'd16;

  // Width of the packed result on the output stream.
  localparam int unsigned RESULT_BITS = 132;
  localparam int unsigned TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_RIFF    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_PAD     = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_t;

  // Expected-format registers as seen by the parser.
  typedef struct packed {
    logic [31:0] rate;
    logic [15:0] channels;
    logic [15:0] bits;
  } expect_t;

  // One result item, last field in the lowest bits of the packed struct.
  typedef struct packed {
    logic        format_ok;
    logic [15:0] sample_bits;
    logic [15:0] channel_count;
    logic [31:0] fmt_rate;
    logic [31:0] pcm_length;
    logic [31:0] pcm_offset;
    logic [2:0]  status;
  } result_t;

endpackage

[hdl/wav_riff_header_parser_core.sv]
// WAV header parser. Takes a WAV file as a stream of one byte per item on the
// slave side, with tlast on the final byte, and gives one result item per file
// on the master side: a status (0 ok, 1 bad header, 2 bad size, 3 not PCM,
// 4 chunk missing), the data chunk offset and size, the fmt chunk fields and a
// match flag against the expected-format registers. One byte is taken every
// cycle unless a final byte is waiting in the input register; each byte passes
// through the input register to the parser, and a result item is captured in
// the output register as its final byte leaves the input register. The only
// stall comes from the single output register: a final byte waits in the input
// register while an earlier result is still untaken. Configuration writes are
// taken at any time through cfg_valid/cfg_ready and should be made between files.
module wav_riff_header_parser_core (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream: tdata = data_byte[7:0]; tlast = last_byte.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  // Result stream, tdata from bit 0 up: status[2:0], pcm_offset[31:0],
  // payload size[31:0], fmt sample rate[31:0], channel_count[15:0],
  // sample_bits[15:0], format_ok, zero padding to 136 bits.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wrhp_pkg::TDATA_BITS-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               out_free;
  logic               advance;
  wrhp_pkg::expect_t  expected;
  wrhp_pkg::result_t  result;
  wrhp_pkg::result_t  result_reg;

  // The registered byte moves on unless it is a final byte facing a full output.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Expected-format registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected.rate     <= wrhp_pkg::RESET_RATE;
      expected.channels <= wrhp_pkg::RESET_CHANNELS;
      expected.bits     <= wrhp_pkg::RESET_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wrhp_pkg::REG_EXPECTED_RATE:     expected.rate     <= cfg_data;
        wrhp_pkg::REG_EXPECTED_CHANNELS: expected.channels <= cfg_data[15:0];
        wrhp_pkg::REG_EXPECTED_BITS:     expected.bits     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wrhp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .expected  (expected),
    .result    (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      result_reg <= result;
    end
  end

  assign m_axis_tdata = {{(wrhp_pkg::TDATA_BITS - wrhp_pkg::RESULT_BITS){1'b0}}, result_reg};

endmodule

[hdl/wrhp_parser.sv]
module wrhp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  wrhp_pkg::expect_t  expected,
  output wrhp_pkg::result_t  result
);

  wrhp_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [2:0]  header_pos, header_pos_next;
  logic [15:0] format_word, format_word_next;
  logic [31:0] captured_rate, captured_rate_next;
  logic [15:0] captured_channels, captured_channels_next;
  logic [15:0] captured_bits, captured_bits_next;
  logic [31:0] data_start, data_start_next;
  logic [31:0] data_length, data_length_next;
  logic [1:0]  seen_flags, seen_flags_next;
  logic [2:0]  error_latch, error_latch_next;
  logic        chunk_end;
  logic [31:0] payload_idx;
  logic [2:0]  status;

  assign payload_idx = chunk_len - chunk_remaining;

  // Per-byte state update.
  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    tag_shift_next         = tag_shift;
    chunk_len_next         = chunk_len;
    chunk_remaining_next   = chunk_remaining;
    header_pos_next        = header_pos;
    format_word_next       = format_word;
    captured_rate_next     = captured_rate;
    captured_channels_next = captured_channels;
    captured_bits_next     = captured_bits;
    data_start_next        = data_start;
    data_length_next       = data_length;
    seen_flags_next        = seen_flags;
    error_latch_next       = error_latch;
    chunk_end              = 1'b0;

    if (take) begin
      // The byte counter sticks at its maximum.
      if (byte_count != '1) begin
        byte_count_next = byte_count + 32'd1;
      end

      case (phase)
        wrhp_pkg::PH_RIFF: begin
          tag_shift_next = {tag_shift[23:0], data_byte};
          if (byte_count == wrhp_pkg::RIFF_TAG_END && tag_shift_next != wrhp_pkg::TAG_RIFF) begin
            error_latch_next = wrhp_pkg::ST_HEADER;
            phase_next       = wrhp_pkg::PH_HALT;
          end else if (byte_count == wrhp_pkg::WAVE_TAG_END) begin
            if (tag_shift_next != wrhp_pkg::TAG_WAVE) begin
              error_latch_next = wrhp_pkg::ST_HEADER;
              phase_next       = wrhp_pkg::PH_HALT;
            end else begin
              phase_next      = wrhp_pkg::PH_HEADER;
              header_pos_next = 3'd0;
            end
          end
        end

        wrhp_pkg::PH_HEADER: begin
          // Tag bytes first, then the little-endian size.
          if (header_pos < 3'd4) begin
            tag_shift_next = {tag_shift[23:0], data_byte};
          end else begin
            chunk_len_next = {data_byte, chunk_len[31:8]};
          end
          if (header_pos != 3'd7) begin
            header_pos_next = header_pos + 3'd1;
          end else begin
            header_pos_next      = 3'd0;
            chunk_remaining_next = chunk_len_next;
            if (tag_shift == wrhp_pkg::TAG_FMT && chunk_len_next < wrhp_pkg::MIN_FMT_BYTES) begin
              error_latch_next = wrhp_pkg::ST_SIZE;
              phase_next       = wrhp_pkg::PH_HALT;
            end else begin
              if (tag_shift == wrhp_pkg::TAG_DATA) begin
                data_start_next  = byte_count_next;
                data_length_next = chunk_len_next;
              end
              if (chunk_len_next == '0) begin
                chunk_end = 1'b1;
              end else begin
                phase_next = wrhp_pkg::PH_PAYLOAD;
              end
            end
          end
        end

        wrhp_pkg::PH_PAYLOAD: begin
          // Capture the fields of the first sixteen bytes of a fmt chunk.
          if (tag_shift == wrhp_pkg::TAG_FMT && payload_idx[31:4] == '0) begin
            case (payload_idx[3:0])
              4'd0:    format_word_next[7:0]         = data_byte;
              4'd1:    format_word_next[15:8]        = data_byte;
              4'd2:    captured_channels_next[7:0]   = data_byte;
              4'd3:    captured_channels_next[15:8]  = data_byte;
              4'd4:    captured_rate_next[7:0]       = data_byte;
              4'd5:    captured_rate_next[15:8]      = data_byte;
              4'd6:    captured_rate_next[23:16]     = data_byte;
              4'd7:    captured_rate_next[31:24]     = data_byte;
              4'd14:   captured_bits_next[7:0]       = data_byte;
              4'd15:   captured_bits_next[15:8]      = data_byte;
              default: ;
            endcase
          end
          chunk_remaining_next = chunk_remaining - 32'd1;
          if (chunk_remaining_next == '0) begin
            chunk_end = 1'b1;
          end
        end

        wrhp_pkg::PH_PAD: begin
          phase_next      = wrhp_pkg::PH_HEADER;
          header_pos_next = 3'd0;
        end

        default: ;
      endcase

      // End of a chunk payload: check the format word and note what was seen.
      if (chunk_end) begin
        if (tag_shift_next == wrhp_pkg::TAG_FMT && format_word_next != wrhp_pkg::FORMAT_PCM) begin
          error_latch_next = wrhp_pkg::ST_NOT_PCM;
          phase_next       = wrhp_pkg::PH_HALT;
        end else begin
          if (tag_shift_next == wrhp_pkg::TAG_FMT) begin
            seen_flags_next[0] = 1'b1;
          end else if (tag_shift_next == wrhp_pkg::TAG_DATA) begin
            seen_flags_next[1] = 1'b1;
          end
          phase_next      = chunk_len_next[0] ? wrhp_pkg::PH_PAD : wrhp_pkg::PH_HEADER;
          header_pos_next = 3'd0;
        end
      end
    end
  end

  // Status of the file as it stands after this byte.
  always_comb begin
    if (byte_count_next < wrhp_pkg::MIN_FILE_BYTES) begin
      status = wrhp_pkg::ST_HEADER;
    end else if (error_latch_next != wrhp_pkg::ST_OK) begin
      status = error_latch_next;
    end else if (phase_next == wrhp_pkg::PH_PAYLOAD) begin
      status = wrhp_pkg::ST_SIZE;
    end else if (seen_flags_next != 2'b11 || data_length_next == '0) begin
      status = wrhp_pkg::ST_MISSING;
    end else begin
      status = wrhp_pkg::ST_OK;
    end
  end

  always_comb begin
    result.status        = status;
    result.pcm_offset    = data_start_next;
    result.pcm_length    = data_length_next;
    result.fmt_rate      = captured_rate_next;
    result.channel_count = captured_channels_next;
    result.sample_bits   = captured_bits_next;
    result.format_ok     = (status == wrhp_pkg::ST_OK) &&
                           (captured_rate_next == expected.rate) &&
                           (captured_channels_next == expected.channels) &&
                           (captured_bits_next == expected.bits);
  end

  // State registers; the final byte of a file clears them for the next one.
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase             <= wrhp_pkg::PH_RIFF;
      byte_count        <= '0;
      tag_shift         <= '0;
      chunk_len         <= '0;
      chunk_remaining   <= '0;
      header_pos        <= '0;
      format_word       <= '0;
      captured_rate     <= '0;
      captured_channels <= '0;
      captured_bits     <= '0;
      data_start        <= '0;
      data_length       <= '0;
      seen_flags        <= '0;
      error_latch       <= wrhp_pkg::ST_OK;
    end else begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      tag_shift         <= tag_shift_next;
      chunk_len         <= chunk_len_next;
      chunk_remaining   <= chunk_remaining_next;
      header_pos        <= header_pos_next;
      format_word       <= format_word_next;
      captured_rate     <= captured_rate_next;
      captured_channels <= captured_channels_next;
      captured_bits     <= captured_bits_next;
      data_start        <= data_start_next;
      data_length       <= data_length_next;
      seen_flags        <= seen_flags_next;
      error_latch       <= error_latch_next;
    end
  end

endmodule

[hdl/wrhp_checker.sv]
module wrhp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wrhp_pkg::TDATA_BITS-1:0]  m_axis_tdata
);

  // A result that is not taken stays on the port unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The match flag is only set on a clean file, and status is a known code.
  a_ok_needs_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[131] || m_axis_tdata[2:0] == wrhp_pkg::ST_OK) &&
                      (m_axis_tdata[2:0] <= wrhp_pkg::ST_MISSING))
    else $error("format_ok set with a bad status, or status out of range");

  // Padding bits above the result stay zero.
  a_padding_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[wrhp_pkg::TDATA_BITS-1:wrhp_pkg::RESULT_BITS] == '0)
    else $error("padding bits not zero");

  // With the output empty nothing can hold the input back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result pending");

endmodule

bind wav_riff_header_parser_core wrhp_checker u_wrhp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
